[src/s2d_pkg.sv]
// Shared types and constants for the signed integer to decimal text converter.
package s2d_pkg;

	localparam int ValueWidth = 32;
	localparam int NumDigits  = 10;
	localparam int DigitWidth = 4;
	localparam int CountWidth = $clog2(NumDigits + 1);
	localparam int IndexWidth = $clog2(NumDigits);
	localparam int CharWidth  = 8;
	localparam int FifoDepth  = 2;
	localparam int PtrWidth   = $clog2(FifoDepth);
	localparam int OccWidth   = $clog2(FifoDepth + 1);

	// Reciprocal of ten: floor(x / 10) == (x * Recip) >> RecipShift for any 32-bit x
	localparam logic [ValueWidth-1:0] Recip = 32'hCCCC_CCCD;
	localparam int RecipShift = 35;

	localparam logic [CharWidth-1:0] AsciiZero  = 8'h30;
	localparam logic [CharWidth-1:0] AsciiMinus = 8'h2D;

	// One converted number, digits least significant first
	typedef struct packed {
		logic                                  neg;
		logic [CountWidth-1:0]                 ndig;
		logic [NumDigits-1:0][DigitWidth-1:0]  digits;
	} s2d_rec_t;

	typedef enum logic [1:0] {
		FrIdle,
		FrConv,
		FrHold
	} s2d_front_state_t;

endpackage

[src/s2d_front.sv]
// Front end: accepts a value, forms sign and magnitude, extracts decimal digits.
module s2d_front import s2d_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [ValueWidth-1:0] value,
	input  logic                         full,
	output logic                         busy,
	output logic                         push,
	output s2d_rec_t                     rec
);

	s2d_front_state_t state_q, state_d;

	logic [ValueWidth-1:0]                mag_q;
	logic                                 neg_q;
	logic [IndexWidth-1:0]                cnt_q;
	logic [NumDigits-1:0][DigitWidth-1:0] digits_q;

	logic [ValueWidth-1:0]   raw;
	logic [ValueWidth-1:0]   mag_in;
	logic [2*ValueWidth-1:0] prod;
	logic [ValueWidth-1:0]   quo;
	logic [DigitWidth-1:0]   quo_lo;
	logic [DigitWidth-1:0]   ten_lo;
	logic [DigitWidth-1:0]   digit;
	logic                    final_digit;

	// Form the unsigned magnitude; the most negative value wraps onto itself
	assign raw    = value;
	assign mag_in = raw[ValueWidth-1] ? (ValueWidth'(0) - raw) : raw;

	// Divide by ten through the reciprocal, remainder from the low bits only
	assign prod   = 64'(mag_q) * 64'(Recip);
	assign quo    = ValueWidth'(prod >> RecipShift);
	assign quo_lo = quo[DigitWidth-1:0];
	assign ten_lo = (quo_lo << 3) + (quo_lo << 1);
	assign digit  = mag_q[DigitWidth-1:0] - ten_lo;

	assign final_digit = (quo == '0) || (cnt_q == IndexWidth'(NumDigits - 1));

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FrIdle;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, queue push and the outgoing transaction
	always_comb begin
		state_d    = state_q;
		push       = 1'b0;
		busy       = 1'b1;
		rec.neg    = neg_q;
		rec.ndig   = CountWidth'(cnt_q) + CountWidth'(1);
		rec.digits = digits_q;
		case (state_q)
			FrIdle: begin
				busy = 1'b0;
				if (start) begin
					state_d = FrConv;
				end
			end
			FrConv: begin
				rec.digits[cnt_q] = digit;
				if (final_digit) begin
					if (!full) begin
						push    = 1'b1;
						state_d = FrIdle;
					end else begin
						state_d = FrHold;
					end
				end
			end
			FrHold: begin
				if (!full) begin
					push    = 1'b1;
					state_d = FrIdle;
				end
			end
			default: begin
				state_d = FrIdle;
			end
		endcase
	end

	// Load the magnitude, then advance one digit per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			FrIdle: begin
				if (start) begin
					mag_q <= mag_in;
					neg_q <= raw[ValueWidth-1];
					cnt_q <= '0;
				end
			end
			FrConv: begin
				digits_q[cnt_q] <= digit;
				if (!final_digit) begin
					mag_q <= quo;
					cnt_q <= cnt_q + IndexWidth'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[src/s2d_fifo.sv]
// Short queue of converted numbers between the front and back ends.
module s2d_fifo import s2d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  s2d_rec_t wdata,
	input  logic     pop,
	output logic     full,
	output logic     valid,
	output s2d_rec_t rdata
);

	s2d_rec_t              mem_q [FifoDepth];
	logic [PtrWidth-1:0]   wr_ptr_q;
	logic [PtrWidth-1:0]   rd_ptr_q;
	logic [OccWidth-1:0]   occ_q;

	assign full  = (occ_q == OccWidth'(FifoDepth));
	assign valid = (occ_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrWidth'(FifoDepth - 1)) ? '0
					: wr_ptr_q + PtrWidth'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrWidth'(FifoDepth - 1)) ? '0
					: rd_ptr_q + PtrWidth'(1);
			end
			case ({push, pop})
				2'b10:   occ_q <= occ_q + OccWidth'(1);
				2'b01:   occ_q <= occ_q - OccWidth'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[src/s2d_back.sv]
// Back end: emits the sign and digits of one number, most significant first.
module s2d_back import s2d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	input  s2d_rec_t             rec,
	output logic                 pop,
	output logic                 strobe,
	output logic [CharWidth-1:0] character,
	output logic                 last
);

	logic                                 active_q;
	logic                                 sign_q;
	logic [IndexWidth-1:0]                idx_q;
	logic [NumDigits-1:0][DigitWidth-1:0] digits_q;

	logic final_char;

	assign final_char = active_q && !sign_q && (idx_q == '0);
	assign pop        = valid && (!active_q || final_char);

	// Drive the character from the current position
	assign strobe    = active_q;
	assign last      = final_char;
	assign character = sign_q ? AsciiMinus
		: AsciiZero + CharWidth'(digits_q[idx_q]);

	// Track activity and the pending sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
		end else if (pop) begin
			active_q <= 1'b1;
			sign_q   <= rec.neg;
		end else if (active_q) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q == '0) begin
				active_q <= 1'b0;
			end
		end
	end

	// Load a new number, then step down through its digits
	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q    <= IndexWidth'(rec.ndig - CountWidth'(1));
			digits_q <= rec.digits;
		end else if (active_q && !sign_q && (idx_q != '0)) begin
			idx_q <= idx_q - IndexWidth'(1);
		end
	end

endmodule

[src/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text: top level.
//
// A value is taken when start is high and busy is low. The front end then
// extracts one decimal digit per cycle with a reciprocal multiply by one
// tenth, so busy stays high while the value's digits (1 to 10) are
// extracted, and longer only if the two-entry queue to the back end is full.
// The back end emits one character per cycle on strobe: '-' for a negative
// value, then the digits most significant first, with last on the final
// digit. A number yields 1 to 11 characters in consecutive cycles. Front
// and back overlap, so the next value converts while the previous one is
// sent. The sustained rate is set by the front end, which accepts a value
// and then extracts its digits; the character stream of a number never
// takes longer than that.
// Results cannot be held off; the receiver must take each strobe.
module signed_int_to_decimal_ascii import s2d_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [ValueWidth-1:0] value,
	output logic                         strobe,
	output logic [CharWidth-1:0]         character,
	output logic                         last
);

	s2d_rec_t push_rec;
	s2d_rec_t head_rec;
	logic     push;
	logic     pop;
	logic     full;
	logic     head_valid;

	s2d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.full   (full),
		.busy   (busy),
		.push   (push),
		.rec    (push_rec)
	);

	s2d_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_rec),
		.pop    (pop),
		.full   (full),
		.valid  (head_valid),
		.rdata  (head_rec)
	);

	s2d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (head_valid),
		.rec       (head_rec),
		.pop       (pop),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	// Every character is a minus sign or a decimal digit
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == AsciiMinus
			|| (character >= AsciiZero && character <= AsciiZero + CharWidth'(9))))
		else $error("character outside sign and digit set");

	// A minus sign is never last and is followed at once by a digit
	a_sign_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && character == AsciiMinus) |-> !last ##1 (strobe && character != AsciiMinus))
		else $error("minus sign not followed by a digit");

	// The front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue overflow");

	// An accepted transaction makes the block busy in the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the signed integer to decimal ASCII converter.
module tb_top;
	import s2d_pkg::*;

	localparam logic [CharWidth-1:0] CharZero  = 8'h30;
	localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
	localparam int NumRandom  = 390;
	localparam int CalmTail   = 60;
	localparam int TailCycles = 40;
	localparam int DrainLimit = 2000;

	typedef struct packed {
		logic [CharWidth-1:0] ch;
		logic                 fin;
	} text_char_t;

	// Expected text of every accepted value, oldest character first
	class text_scoreboard;
		text_char_t expected_text[$];
		int mismatches;
		int values_seen;
		int negatives_seen;
		int chars_checked;

		function new();
			mismatches     = 0;
			values_seen    = 0;
			negatives_seen = 0;
			chars_checked  = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		// Work out the decimal text of an accepted value and queue it
		function void note_value(input logic [ValueWidth-1:0] v);
			logic [ValueWidth-1:0] mag;
			logic [DigitWidth-1:0] digit_buf [NumDigits];
			int n;
			text_char_t tc;
			values_seen++;
			mag = v[ValueWidth-1] ? (32'd0 - v) : v;
			if (v[ValueWidth-1]) begin
				negatives_seen++;
				tc.ch  = CharMinus;
				tc.fin = 1'b0;
				expected_text.push_back(tc);
			end
			n = 0;
			do begin
				digit_buf[n] = DigitWidth'(mag % 10);
				mag = mag / 10;
				n++;
			end while (mag != 0 && n < NumDigits);
			for (int k = n - 1; k >= 0; k--) begin
				tc.ch  = CharZero + CharWidth'(digit_buf[k]);
				tc.fin = (k == 0);
				expected_text.push_back(tc);
			end
		endfunction

		// Compare one result transaction with the oldest expectation
		task check_result(input logic [CharWidth-1:0] ch, input logic fin);
			text_char_t want;
			chars_checked++;
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected character %h last %b", ch, fin));
			end else begin
				want = expected_text.pop_front();
				if (ch !== want.ch)
					report_mismatch($sformatf("character %h, wanted %h", ch, want.ch));
				if (fin !== want.fin)
					report_mismatch($sformatf("last %b, wanted %b", fin, want.fin));
			end
		endtask

		task check_leftover();
			if (expected_text.size() != 0)
				report_mismatch($sformatf("%0d characters never arrived",
					expected_text.size()));
		endtask
	endclass

	logic                         clk    = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start  = 1'b0;
	logic signed [ValueWidth-1:0] value  = '0;
	logic                         busy;
	logic                         strobe;
	logic [CharWidth-1:0]         character;
	logic                         last;

	text_scoreboard sb = new();

	int directed_values [] = '{
		0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345,
		999999999, -999999999, 1000000000, -1000000000,
		1234567890, -1234567890, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF,
		32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA
	};

	signed_int_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check every strobed character at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(character, last);
	end

	// Offer one value and hold it until the block takes it
	task automatic send_value(input logic [ValueWidth-1:0] v);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		sb.note_value(v);
	endtask

	// Drop start for a burst of idle cycles
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop start and wait until every expected character has come
	task automatic pause_until_drained();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (sb.expected_text.size() != 0 && guard < DrainLimit) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Mix of full-range, small, digit-count-shaped and extreme values
	function automatic logic [ValueWidth-1:0] random_value();
		int kind;
		int unsigned ndig;
		int unsigned lo;
		int unsigned hi;
		int unsigned mag;
		kind = $urandom_range(0, 9);
		if (kind < 3)
			return $urandom;
		if (kind == 9) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'h8000_0000;
				2: return 32'h7FFF_FFFF;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (kind < 5) begin
			mag = $urandom_range(0, 99);
		end else begin
			ndig = $urandom_range(1, NumDigits);
			lo = 1;
			repeat (ndig - 1) lo = lo * 10;
			hi = (ndig == NumDigits) ? 32'h7FFF_FFFF : lo * 10 - 1;
			if (ndig == 1)
				lo = 0;
			mag = $urandom_range(hi, lo);
		end
		return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed extremes and digit-count boundaries
		foreach (directed_values[i]) begin
			send_value(directed_values[i]);
			if ($urandom_range(0, 2) == 0)
				hold_off($urandom_range(1, 8));
		end
		pause_until_drained();

		// Random values, with a drain pause midway and a calm tail
		for (int i = 0; i < NumRandom; i++) begin
			send_value(random_value());
			if (i == NumRandom / 2)
				pause_until_drained();
			else if (i < NumRandom - CalmTail && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 8));
		end

		pause_until_drained();
		repeat (TailCycles) @(posedge clk);
		sb.check_leftover();

		$display("Converted %0d values (%0d negative) and checked %0d characters,",
			sb.values_seen, sb.negatives_seen, sb.chars_checked);
		$display("with idle bursts, drain pauses and the extreme values included.");
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
